/* rtl/rrg_pkg.sv */
package rrg_pkg;

    localparam int MAX_CH    = 4;
    localparam int LOG_STEPS = 16;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 32;

    typedef enum logic [CFG_IW-1:0] {
        REG_IN_LOW,
        REG_IN_HIGH,
        REG_OUT_LOW,
        REG_OUT_HIGH,
        REG_GAMMA,
        REG_CLAMP,
        REG_BYPASS
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] in_low;
        logic signed [31:0] in_high;
        logic signed [31:0] out_low;
        logic signed [31:0] out_high;
        logic [30:0]        gamma_value;
        logic               clamp_enable;
        logic               bypass;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        in_low:       32'sd0,
        in_high:      32'sd65536,
        out_low:      32'sd0,
        out_high:     32'sd65536,
        gamma_value:  31'd65536,
        clamp_enable: 1'b0,
        bypass:       1'b0
    };

    // floor square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) with 30 fraction bits
    function automatic logic [30:0] root_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 2; j <= k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

/* rtl/rrg_div.sv */
module rrg_div
    import rrg_pkg::*;
#(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int SW = 34
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [1:NW];
    logic [NW-1:0] num_reg  [1:NW];
    logic [NW-1:0] quo_reg  [1:NW];
    logic [DW-1:0] den_reg  [1:NW];
    logic [SW-1:0] side_reg [1:NW];
    logic          vld_reg  [1:NW];

    genvar i;
    for (i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [NW-1:0] num_cur;
        logic [NW-1:0] quo_cur;
        logic [SW-1:0] side_cur;
        logic          vld_cur;
        logic [DW:0]   cand;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;
        logic [NW-1:0] num_next;

        if (i == 0) begin : g_first
            assign rem_cur  = '0;
            assign den_cur  = den;
            assign num_cur  = num;
            assign quo_cur  = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_vld;
        end else begin : g_rest
            assign rem_cur  = rem_reg[i];
            assign den_cur  = den_reg[i];
            assign num_cur  = num_reg[i];
            assign quo_cur  = quo_reg[i];
            assign side_cur = side_reg[i];
            assign vld_cur  = vld_reg[i];
        end

        // one restoring step: bring down a dividend bit, subtract when it fits
        always_comb begin
            cand     = {rem_cur, num_cur[NW-1]};
            ge       = (cand >= {1'b0, den_cur});
            rem_next = ge ? DW'(cand - {1'b0, den_cur}) : cand[DW-1:0];
            quo_next = {quo_cur[NW-2:0], ge};
            num_next = num_cur << 1;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= rem_next;
                den_reg[i+1]  <= den_cur;
                num_reg[i+1]  <= num_next;
                quo_reg[i+1]  <= quo_next;
                side_reg[i+1] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[NW];
    assign quo      = quo_reg[NW];
    assign side_out = side_reg[NW];

endmodule

/* rtl/rrg_lane.sv */
module rrg_lane
    import rrg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [31:0] v_in,
    input  cfg_t               cfg,
    output logic               out_vld,
    output logic signed [31:0] res_out
);

    localparam int NW1 = 33 + FRAC_BITS;
    localparam int EW  = $clog2(NW1);
    localparam int NW2 = 23 + FRAC_BITS;
    localparam int IPW = NW2 - 15;
    localparam logic [30:0] GAMMA_ONE = 31'(1) << FRAC_BITS;
    localparam logic [62:0] T_ONE     = 63'(1) << FRAC_BITS;
    localparam logic [62:0] T_MAX     = 63'((64'd1 << 62) - 64'd1);
    localparam logic signed [IPW:0] S_OFF = (IPW+1)'(FRAC_BITS - 30);
    localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

    typedef struct packed {
        logic signed [31:0] v;
        logic               dz;
        logic               neg;
        logic               pw;
        logic [NW1-1:0]     q;
    } carry_t;

    localparam int CARW = $bits(carry_t);

    // ---------------- range offset
    logic signed [32:0] num_c;
    logic signed [32:0] den_c;
    logic [32:0]        un_next;
    logic [32:0]        ud_next;
    logic               vld0_reg;
    logic [32:0]        un_reg;
    logic [32:0]        ud_reg;
    logic               neg0_reg;
    logic               dz0_reg;
    logic signed [31:0] v0_reg;

    always_comb begin
        num_c   = {v_in[31], v_in} - {cfg.in_low[31], cfg.in_low};
        den_c   = {cfg.in_high[31], cfg.in_high} - {cfg.in_low[31], cfg.in_low};
        un_next = num_c[32] ? 33'(-num_c) : 33'(num_c);
        ud_next = den_c[32] ? 33'(-den_c) : 33'(den_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            un_reg   <= un_next;
            ud_reg   <= ud_next;
            neg0_reg <= num_c[32] ^ den_c[32];
            dz0_reg  <= (den_c == '0);
            v0_reg   <= v_in;
        end
    end

    // ---------------- normalize: t = num * 2^F / den
    logic           d1_vld;
    logic [NW1-1:0] d1_q;
    logic [33:0]    d1_side;

    rrg_div #(
        .NW (NW1),
        .DW (33),
        .SW (34)
    ) u_div_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vld0_reg),
        .num      ({un_reg, {FRAC_BITS{1'b0}}}),
        .den      (ud_reg),
        .side_in  ({v0_reg, dz0_reg, neg0_reg}),
        .out_vld  (d1_vld),
        .quo      (d1_q),
        .side_out (d1_side)
    );

    carry_t c1_next;
    carry_t c1_reg;
    logic   vld1_reg;

    always_comb begin
        c1_next.v   = $signed(d1_side[33:2]);
        c1_next.dz  = d1_side[1];
        c1_next.neg = d1_side[0];
        c1_next.pw  = (cfg.gamma_value != GAMMA_ONE) && !d1_side[0] && (d1_q != '0);
        c1_next.q   = d1_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= d1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg <= c1_next;
        end
    end

    // ---------------- leading one
    logic [EW-1:0] e_next;
    logic [EW-1:0] e2_reg;
    carry_t        c2_reg;
    logic          vld2_reg;

    always_comb begin
        e_next = '0;
        for (int i = 0; i < NW1; i++) begin
            if (c1_reg.q[i]) e_next = EW'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e2_reg <= e_next;
            c2_reg <= c1_reg;
        end
    end

    // ---------------- mantissa into [2^30, 2^31), then log fraction by squaring
    logic [30:0]   ysq_reg [0:LOG_STEPS];
    logic [15:0]   fsq_reg [0:LOG_STEPS];
    logic [EW-1:0] esq_reg [0:LOG_STEPS];
    carry_t        csq_reg [0:LOG_STEPS];
    logic          vsq_reg [0:LOG_STEPS];
    logic [63:0]   qx;
    logic [30:0]   y_next;

    always_comb begin
        qx = 64'(c2_reg.q);
        if (e2_reg >= EW'(30)) begin
            y_next = 31'(qx >> (e2_reg - EW'(30)));
        end else begin
            y_next = 31'(qx << (EW'(30) - e2_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsq_reg[0] <= 1'b0;
        end else if (en) begin
            vsq_reg[0] <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ysq_reg[0] <= y_next;
            fsq_reg[0] <= '0;
            esq_reg[0] <= e2_reg;
            csq_reg[0] <= c2_reg;
        end
    end

    genvar k;
    for (k = 0; k < LOG_STEPS; k++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sh;
        logic [30:0] ys_next;
        logic [15:0] fs_next;

        always_comb begin
            sq      = 62'(ysq_reg[k]) * 62'(ysq_reg[k]);
            sh      = sq[61:30];
            ys_next = sh[31] ? sh[31:1] : sh[30:0];
            fs_next = fsq_reg[k] | (16'(sh[31]) << (15 - k));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vsq_reg[k+1] <= 1'b0;
            end else if (en) begin
                vsq_reg[k+1] <= vsq_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ysq_reg[k+1] <= ys_next;
                fsq_reg[k+1] <= fs_next;
                esq_reg[k+1] <= esq_reg[k];
                csq_reg[k+1] <= csq_reg[k];
            end
        end
    end

    // ---------------- log2 with 16 fraction bits, magnitude for the divide
    logic [7:0]         em8;
    logic signed [23:0] lg;
    logic [22:0]        lm_reg;
    logic               lneg_reg;
    carry_t             cl_reg;
    logic               vl_reg;

    always_comb begin
        em8 = 8'(esq_reg[LOG_STEPS]) - 8'(FRAC_BITS);
        lg  = $signed({em8, fsq_reg[LOG_STEPS]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= vsq_reg[LOG_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lm_reg   <= lg[23] ? 23'(-lg) : 23'(lg);
            lneg_reg <= lg[23];
            cl_reg   <= csq_reg[LOG_STEPS];
        end
    end

    // ---------------- scale log by 1/gamma
    logic           d2_vld;
    logic [NW2-1:0] d2_q;
    logic [CARW:0]  d2_side;
    logic [30:0]    g_div;
    carry_t         d2_c;

    assign g_div = (cfg.gamma_value == '0) ? 31'd1 : cfg.gamma_value;

    rrg_div #(
        .NW (NW2),
        .DW (31),
        .SW (CARW + 1)
    ) u_div_gamma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vl_reg),
        .num      ({lm_reg, {FRAC_BITS{1'b0}}}),
        .den      (g_div),
        .side_in  ({cl_reg, lneg_reg}),
        .out_vld  (d2_vld),
        .quo      (d2_q),
        .side_out (d2_side)
    );

    assign d2_c = carry_t'(d2_side[CARW:1]);

    logic signed [NW2:0] ex;
    logic [30:0]           rr_reg [0:LOG_STEPS];
    logic signed [IPW-1:0] ip_reg [0:LOG_STEPS];
    logic [15:0]           fr_reg [0:LOG_STEPS];
    carry_t                cr_reg [0:LOG_STEPS];
    logic                  vr_reg [0:LOG_STEPS];

    always_comb begin
        ex = d2_side[0] ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg[0] <= 1'b0;
        end else if (en) begin
            vr_reg[0] <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg[0] <= 31'(1) << 30;
            ip_reg[0] <= ex[NW2:16];
            fr_reg[0] <= ex[15:0];
            cr_reg[0] <= d2_c;
        end
    end

    // ---------------- exp2 of the fraction: multiply in 2^(2^-k) per set bit
    for (k = 0; k < LOG_STEPS; k++) begin : g_root
        localparam logic [30:0] CK = root_const(k + 1);
        logic [61:0] pr;
        logic [30:0] rr_next;

        always_comb begin
            pr      = 62'(rr_reg[k]) * 62'(CK);
            rr_next = fr_reg[k][15-k] ? pr[60:30] : rr_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vr_reg[k+1] <= 1'b0;
            end else if (en) begin
                vr_reg[k+1] <= vr_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rr_reg[k+1] <= rr_next;
                ip_reg[k+1] <= ip_reg[k];
                fr_reg[k+1] <= fr_reg[k];
                cr_reg[k+1] <= cr_reg[k];
            end
        end
    end

    // ---------------- integer part as a shift, saturate
    logic signed [IPW:0] sft;
    logic signed [IPW:0] nsft;
    logic [62:0]         tp_next;
    logic [62:0]         tp_reg;
    carry_t              cs_reg;
    logic                vs_reg;

    always_comb begin
        sft  = $signed({ip_reg[LOG_STEPS][IPW-1], ip_reg[LOG_STEPS]}) + S_OFF;
        nsft = -sft;
        if (sft > 31) begin
            tp_next = T_MAX;
        end else if (sft >= 0) begin
            tp_next = 63'(rr_reg[LOG_STEPS]) << sft[4:0];
        end else if (sft < -30) begin
            tp_next = '0;
        end else begin
            tp_next = 63'(rr_reg[LOG_STEPS]) >> nsft[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (en) begin
            vs_reg <= vr_reg[LOG_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tp_reg <= tp_next;
            cs_reg <= cr_reg[LOG_STEPS];
        end
    end

    // ---------------- pick power or linear t, clamp
    logic [62:0]        tm_next;
    logic               tn_next;
    logic [62:0]        tm_reg;
    logic               tneg_reg;
    logic signed [31:0] vc_reg;
    logic               dzc_reg;
    logic               vc_vld_reg;

    always_comb begin
        if (cs_reg.pw) begin
            tm_next = tp_reg;
            tn_next = 1'b0;
        end else begin
            tm_next = 63'(cs_reg.q);
            tn_next = cs_reg.neg && (cs_reg.q != '0);
        end
        if (cfg.clamp_enable) begin
            if (tn_next) begin
                tm_next = '0;
                tn_next = 1'b0;
            end else if (tm_next > T_ONE) begin
                tm_next = T_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_vld_reg <= 1'b0;
        end else if (en) begin
            vc_vld_reg <= vs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tm_reg   <= tm_next;
            tneg_reg <= tn_next;
            vc_reg   <= cs_reg.v;
            dzc_reg  <= cs_reg.dz;
        end
    end

    // ---------------- t * (out_high - out_low), two partial products
    logic signed [32:0] dspan;
    logic [31:0]        dm;
    logic [63:0]        plo_reg;
    logic [62:0]        phi_reg;
    logic               pneg1_reg;
    logic signed [31:0] vm1_reg;
    logic               dzm1_reg;
    logic               vm1_vld_reg;

    always_comb begin
        dspan = {cfg.out_high[31], cfg.out_high} - {cfg.out_low[31], cfg.out_low};
        dm    = dspan[32] ? 32'(-dspan) : 32'(dspan);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_vld_reg <= 1'b0;
        end else if (en) begin
            vm1_vld_reg <= vc_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg   <= 64'(tm_reg[31:0]) * 64'(dm);
            phi_reg   <= 63'(tm_reg[62:32]) * 63'(dm);
            pneg1_reg <= tneg_reg ^ dspan[32];
            vm1_reg   <= vc_reg;
            dzm1_reg  <= dzc_reg;
        end
    end

    logic [94:0]        prod;
    logic [63:0]        qm_reg;
    logic               ovf_reg;
    logic               pneg2_reg;
    logic signed [31:0] vm2_reg;
    logic               dzm2_reg;
    logic               vm2_vld_reg;

    assign prod = {phi_reg, 32'd0} + 95'(plo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm2_vld_reg <= 1'b0;
        end else if (en) begin
            vm2_vld_reg <= vm1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qm_reg    <= 64'(prod >> FRAC_BITS);
            ovf_reg   <= (prod > (95'(1) << 62));
            pneg2_reg <= pneg1_reg;
            vm2_reg   <= vm1_reg;
            dzm2_reg  <= dzm1_reg;
        end
    end

    // ---------------- offset, saturate, special cases
    logic signed [64:0] sum;
    logic signed [31:0] res_next;
    logic signed [31:0] res_reg;
    logic               vo_reg;

    always_comb begin
        sum = $signed({{33{cfg.out_low[31]}}, cfg.out_low})
            + (pneg2_reg ? -$signed({1'b0, qm_reg}) : $signed({1'b0, qm_reg}));
        if (cfg.bypass) begin
            res_next = vm2_reg;
        end else if (dzm2_reg) begin
            res_next = cfg.out_low;
        end else if (ovf_reg) begin
            res_next = pneg2_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (sum > S32_MAX) begin
            res_next = 32'sh7fff_ffff;
        end else if (sum < S32_MIN) begin
            res_next = 32'sh8000_0000;
        end else begin
            res_next = 32'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vm2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_vld = vo_reg;
    assign res_out = res_reg;

endmodule

/* rtl/rrg_merge.sv */
module rrg_merge
    import rrg_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CHANNELS-1:0] lane_vld,
    input  logic signed [31:0]  lane_res [CHANNELS],
    input  logic                m_ready,
    output logic                en,
    output logic                m_valid,
    output logic signed [31:0]  m_data [MAX_CH]
);

    logic               arrive;
    logic               o_vld_reg;
    logic               sk_vld_reg;
    logic signed [31:0] o_data_reg  [CHANNELS];
    logic signed [31:0] sk_data_reg [CHANNELS];
    logic               o_vld_next;
    logic               sk_vld_next;
    logic               take_out;

    // lanes advance only while the skid slot is free
    assign en       = !sk_vld_reg;
    assign arrive   = en && (&lane_vld);
    assign take_out = !o_vld_reg || m_ready;

    always_comb begin
        o_vld_next  = o_vld_reg;
        sk_vld_next = sk_vld_reg;
        if (take_out) begin
            o_vld_next  = sk_vld_reg || arrive;
            sk_vld_next = 1'b0;
        end else if (arrive) begin
            sk_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg  <= 1'b0;
            sk_vld_reg <= 1'b0;
        end else begin
            o_vld_reg  <= o_vld_next;
            sk_vld_reg <= sk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < CHANNELS; j++) begin
            if (take_out) begin
                o_data_reg[j] <= sk_vld_reg ? sk_data_reg[j] : lane_res[j];
            end else if (arrive) begin
                sk_data_reg[j] <= lane_res[j];
            end
        end
    end

    assign m_valid = o_vld_reg;

    genvar i;
    for (i = 0; i < MAX_CH; i++) begin : g_out
        if (i < CHANNELS) begin : g_used
            assign m_data[i] = o_data_reg[i];
        end else begin : g_unused
            assign m_data[i] = '0;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_vld_reg |-> o_vld_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sk_vld_reg) |-> $past(o_vld_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (sk_vld_reg && m_ready) |=> (o_vld_reg && !sk_vld_reg))
        else $error("skid beat not moved to output");

endmodule

/* rtl/range_remap_gamma.sv */
// Pipeline: two bit-per-stage dividers, 16 log squaring and 16 exp multiply stages.
// Throughput: one beat per cycle while the skid slot is free; that slot lets one more
//   beat in while output stalls.
// Reset (aresetn low, synchronous): pipeline and output valids clear, registers take
//   their defaults (input and output range 0..1.0, gamma 1.0, clamp and bypass off).
module range_remap_gamma
    import rrg_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_ch0_in,
    input  logic signed [31:0]    s_ch1_in,
    input  logic signed [31:0]    s_ch2_in,
    input  logic signed [31:0]    s_ch3_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_ch0_out,
    output logic signed [31:0]    m_ch1_out,
    output logic signed [31:0]    m_ch2_out,
    output logic signed [31:0]    m_ch3_out,
    input  logic                  cfg_we,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_wdata
);

    cfg_t               cfg_reg;
    logic               en;
    logic signed [31:0] in_ch    [MAX_CH];
    logic signed [31:0] lane_res [CHANNELS];
    logic [CHANNELS-1:0] lane_vld;
    logic signed [31:0] m_data   [MAX_CH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_IN_LOW:   cfg_reg.in_low       <= $signed(cfg_wdata);
                REG_IN_HIGH:  cfg_reg.in_high      <= $signed(cfg_wdata);
                REG_OUT_LOW:  cfg_reg.out_low      <= $signed(cfg_wdata);
                REG_OUT_HIGH: cfg_reg.out_high     <= $signed(cfg_wdata);
                REG_GAMMA:    cfg_reg.gamma_value  <= cfg_wdata[30:0];
                REG_CLAMP:    cfg_reg.clamp_enable <= cfg_wdata[0];
                REG_BYPASS:   cfg_reg.bypass       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_ch[0] = s_ch0_in;
    assign in_ch[1] = s_ch1_in;
    assign in_ch[2] = s_ch2_in;
    assign in_ch[3] = s_ch3_in;

    assign s_ready = en;

    genvar i;
    for (i = 0; i < CHANNELS; i++) begin : g_lane
        rrg_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (s_valid),
            .v_in    (in_ch[i]),
            .cfg     (cfg_reg),
            .out_vld (lane_vld[i]),
            .res_out (lane_res[i])
        );
    end

    rrg_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_vld (lane_vld),
        .lane_res (lane_res),
        .m_ready  (m_ready),
        .en       (en),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

    assign m_ch0_out = m_data[0];
    assign m_ch1_out = m_data[1];
    assign m_ch2_out = m_data[2];
    assign m_ch3_out = m_data[3];

endmodule
